// ===== rtl/text_command_line_decoder_unit_defines.svh =====
// Assertion macros shared by the command line decoder RTL.
`ifndef TEXT_COMMAND_LINE_DECODER_UNIT_DEFINES_SVH
`define TEXT_COMMAND_LINE_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define TCLD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("command line decoder check failed");
// Check a property on every clock edge, reset included.
`define TCLD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("command line decoder check failed");
`else
`define TCLD_ASSERT(lbl, clk, rst_n, prop)
`define TCLD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/tcld_pkg.sv =====
// Package with the types, codes and keyword table of the command line decoder.
`default_nettype none
package tcld_pkg;

  localparam int CMD_W   = 4;
  localparam int RATE_W  = 31;
  localparam int KEPT    = 3;
  localparam int WORD_W  = 4;
  localparam int NUM_WORDS = 13;

  localparam logic [RATE_W-1:0] RATE_MAX = 31'h7FFF_FFFF;

  // Command codes of the result.
  localparam logic [CMD_W-1:0] CMD_NONE       = 4'd0;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PING       = 4'd2;
  localparam logic [CMD_W-1:0] CMD_STREAM_ON  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_STREAM_OFF = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RATE       = 4'd5;
  localparam logic [CMD_W-1:0] CMD_OTOS_RESET = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CAL_CARPET = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CAL_WHITE  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_CAL_SAVE   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_CAL_LOAD   = 4'd10;
  localparam logic [CMD_W-1:0] CMD_AUTO_ON    = 4'd11;
  localparam logic [CMD_W-1:0] CMD_AUTO_OFF   = 4'd12;

  // Keyword indexes into the word table.
  localparam int W_PING   = 0;
  localparam int W_STREAM = 1;
  localparam int W_ON     = 2;
  localparam int W_OFF    = 3;
  localparam int W_RATE   = 4;
  localparam int W_OTOS   = 5;
  localparam int W_RESET  = 6;
  localparam int W_CAL    = 7;
  localparam int W_CARPET = 8;
  localparam int W_WHITE  = 9;
  localparam int W_SAVE   = 10;
  localparam int W_LOAD   = 11;
  localparam int W_AUTO   = 12;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Control handed to a token tracker for one byte.
  typedef struct packed {
    logic       clear;
    logic       store;
    logic [7:0] ch;
  } slot_ctl_t;

  // Keyword text, first character in the lowest byte, zero padded.
  function automatic logic [47:0] word_text(input logic [WORD_W-1:0] idx);
    logic [47:0] t;
    case (idx)
      4'(W_PING):   t = {16'h0, "G", "N", "I", "P"};
      4'(W_STREAM): t = {"M", "A", "E", "R", "T", "S"};
      4'(W_ON):     t = {32'h0, "N", "O"};
      4'(W_OFF):    t = {24'h0, "F", "F", "O"};
      4'(W_RATE):   t = {16'h0, "E", "T", "A", "R"};
      4'(W_OTOS):   t = {16'h0, "S", "O", "T", "O"};
      4'(W_RESET):  t = {8'h0, "T", "E", "S", "E", "R"};
      4'(W_CAL):    t = {24'h0, "L", "A", "C"};
      4'(W_CARPET): t = {"T", "E", "P", "R", "A", "C"};
      4'(W_WHITE):  t = {8'h0, "E", "T", "I", "H", "W"};
      4'(W_SAVE):   t = {16'h0, "E", "V", "A", "S"};
      4'(W_LOAD):   t = {16'h0, "D", "A", "O", "L"};
      4'(W_AUTO):   t = {16'h0, "O", "T", "U", "A"};
      default:      t = 48'h0;
    endcase
    return t;
  endfunction

  // Character of a keyword at a position; zero past its end.
  function automatic logic [7:0] word_char(input logic [WORD_W-1:0] idx,
                                           input logic [3:0] pos);
    logic [47:0] t;
    logic [7:0]  c;
    t = word_text(idx);
    if (pos < 4'd6) begin
      c = t[{pos[2:0], 3'b000} +: 8];
    end else begin
      c = CH_NUL;
    end
    return c;
  endfunction

  // Length of a keyword.
  function automatic logic [2:0] word_len(input logic [WORD_W-1:0] idx);
    logic [2:0] n;
    case (idx)
      4'(W_PING), 4'(W_RATE), 4'(W_OTOS), 4'(W_SAVE), 4'(W_LOAD),
      4'(W_AUTO):                          n = 3'd4;
      4'(W_STREAM), 4'(W_CARPET):          n = 3'd6;
      4'(W_ON):                            n = 3'd2;
      4'(W_OFF), 4'(W_CAL):                n = 3'd3;
      4'(W_RESET), 4'(W_WHITE):            n = 3'd5;
      default:                             n = 3'd0;
    endcase
    return n;
  endfunction

  // Whitespace or comma.
  function automatic logic is_sep(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_COMMA) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tcld_token_slot.sv =====
// Tracks one stored token: its significant length and which keywords it still matches.
`default_nettype none
module tcld_token_slot #(
  parameter int TOKEN_SLOT_BYTES = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tcld_pkg::slot_ctl_t        ctl,
  output logic [tcld_pkg::NUM_WORDS-1:0]  hit,
  output logic                            sig_app
);

  localparam int SIG_W     = $clog2(TOKEN_SLOT_BYTES);
  localparam int TOK_CHARS = TOKEN_SLOT_BYTES - 1;

  logic [tcld_pkg::NUM_WORDS-1:0] match_r, match_upd, match_nxt;
  logic [SIG_W-1:0]               siglen_r, siglen_upd, siglen_nxt;
  logic                           term_r, term_upd, term_nxt;
  logic                           room;
  logic                           nul_in;

  // A byte is kept only while the slot has room and no NUL has ended the text.
  assign room    = ctl.store && !term_r && (siglen_r < SIG_W'(TOK_CHARS));
  assign sig_app = room && (ctl.ch != tcld_pkg::CH_NUL);
  assign nul_in  = room && (ctl.ch == tcld_pkg::CH_NUL);

  // Narrow the keyword candidates with the new character.
  always_comb begin
    match_upd  = match_r;
    siglen_upd = siglen_r;
    term_upd   = term_r;
    if (sig_app) begin
      siglen_upd = siglen_r + SIG_W'(1);
      for (int w = 0; w < tcld_pkg::NUM_WORDS; w++) begin
        match_upd[w] = match_r[w] &&
          (tcld_pkg::word_char(tcld_pkg::WORD_W'(w), 4'(siglen_r)) == ctl.ch);
      end
    end
    if (nul_in) begin
      term_upd = 1'b1;
    end
  end

  // A keyword is hit when every character matched and the lengths agree.
  always_comb begin
    for (int w = 0; w < tcld_pkg::NUM_WORDS; w++) begin
      hit[w] = match_upd[w] &&
        (siglen_upd == SIG_W'(tcld_pkg::word_len(tcld_pkg::WORD_W'(w))));
    end
  end

  always_comb begin
    if (ctl.clear) begin
      match_nxt  = '1;
      siglen_nxt = '0;
      term_nxt   = 1'b0;
    end else begin
      match_nxt  = match_upd;
      siglen_nxt = siglen_upd;
      term_nxt   = term_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r  <= '1;
      siglen_r <= '0;
      term_r   <= 1'b0;
    end else begin
      match_r  <= match_nxt;
      siglen_r <= siglen_nxt;
      term_r   <= term_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcld_rate_acc.sv =====
// Parses the rate argument: optional sign, then decimal digits, saturating.
`default_nettype none
module tcld_rate_acc (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tcld_pkg::slot_ctl_t           ctl,
  output logic                               ok,
  output logic [tcld_pkg::RATE_W-1:0]        value
);

  logic                        started_r, started_upd, started_nxt;
  logic                        bad_r, bad_upd, bad_nxt;
  logic                        neg_r, neg_upd, neg_nxt;
  logic                        digit_r, digit_upd, digit_nxt;
  logic [tcld_pkg::RATE_W-1:0] acc_r, acc_upd, acc_nxt;
  logic                        is_digit;
  logic                        is_sign;
  logic [tcld_pkg::RATE_W+3:0] wide;

  assign is_digit = (ctl.ch >= tcld_pkg::CH_0) && (ctl.ch <= tcld_pkg::CH_9);
  assign is_sign  = (ctl.ch == tcld_pkg::CH_PLUS) || (ctl.ch == tcld_pkg::CH_MINUS);

  // acc * 10 + digit, as the sum of two shifted copies and the digit.
  assign wide = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {31'h0, ctl.ch[3:0]};

  // Per-character parse step on the significant text of the token.
  always_comb begin
    started_upd = started_r;
    bad_upd     = bad_r;
    neg_upd     = neg_r;
    digit_upd   = digit_r;
    acc_upd     = acc_r;
    if (ctl.store) begin
      started_upd = 1'b1;
      if (is_digit) begin
        digit_upd = 1'b1;
        if (wide[tcld_pkg::RATE_W+3:tcld_pkg::RATE_W] != 4'h0) begin
          acc_upd = tcld_pkg::RATE_MAX;
        end else begin
          acc_upd = wide[tcld_pkg::RATE_W-1:0];
        end
      end else if (is_sign && !started_r) begin
        neg_upd = (ctl.ch == tcld_pkg::CH_MINUS);
      end else begin
        bad_upd = 1'b1;
      end
    end
  end

  assign ok    = digit_upd && !bad_upd && !neg_upd && (acc_upd != '0);
  assign value = acc_upd;

  always_comb begin
    if (ctl.clear) begin
      started_nxt = 1'b0;
      bad_nxt     = 1'b0;
      neg_nxt     = 1'b0;
      digit_nxt   = 1'b0;
      acc_nxt     = '0;
    end else begin
      started_nxt = started_upd;
      bad_nxt     = bad_upd;
      neg_nxt     = neg_upd;
      digit_nxt   = digit_upd;
      acc_nxt     = acc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      bad_r     <= 1'b0;
      neg_r     <= 1'b0;
      digit_r   <= 1'b0;
      acc_r     <= '0;
    end else begin
      started_r <= started_nxt;
      bad_r     <= bad_nxt;
      neg_r     <= neg_nxt;
      digit_r   <= digit_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/text_command_line_decoder_unit.sv =====
// Command line decoder: turns a byte stream of text lines into command codes.
//
// Input channel in_*: one character per transfer in in_tdata, in_tlast set on
// the final byte of a line. Output channel out_*: one result per line, holding
// the command code and, for RATE, the rate argument in hertz.
// Each byte is taken into an input register and from there applied to the
// token trackers; the keyword matches are updated incrementally, so the
// result of a line is ready in the cycle its last byte is processed.
// The result of a line passes the input register and then the result
// register before it is offered on out_*.
// Throughput: one byte per cycle, unless a line end waits for a free result register.
// A line is decoded with no gap before the next line's first byte.
// When the receiver stalls, the result waits in the output register; bytes
// that give no result keep flowing, and the input only stops when a second
// line end reaches the tracker while the first result is still unread.
// After reset all token state is clear and both channels are empty; the
// trackers also clear themselves after every line end.
`default_nettype none
`include "text_command_line_decoder_unit_defines.svh"
module text_command_line_decoder_unit #(
  parameter int MAX_TOKENS       = 4,
  parameter int TOKEN_SLOT_BYTES = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // line_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [3:0] command, [34:4] rate_value, [39:35] zero
);

  localparam int CNT_W = $clog2(MAX_TOKENS + 1);
  localparam int KEPT  = tcld_pkg::KEPT;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       out_free;

  // Token bookkeeping.
  logic             inside_r, inside_upd, inside_nxt;
  logic             rec_r, rec_upd, rec_nxt;
  logic [CNT_W-1:0] count_r, count_upd, count_nxt;
  logic             sep;
  logic             store;
  logic [7:0]       ch_up;
  logic             line_done;

  tcld_pkg::slot_ctl_t            slot_ctl [KEPT];
  logic [tcld_pkg::NUM_WORDS-1:0] hit      [KEPT];
  logic                           sig_app  [KEPT];
  tcld_pkg::slot_ctl_t            rate_ctl;
  logic                           rate_ok;
  logic [tcld_pkg::RATE_W-1:0]    rate_val;

  // Result register.
  logic                        out_valid_r, out_valid_nxt;
  logic [tcld_pkg::CMD_W-1:0]  out_cmd_r, cmd;
  logic [tcld_pkg::RATE_W-1:0] out_rate_r, rate;

  // A line end may only be processed when the result register is free.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign line_done = s1_go && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Token start and count.
  assign sep = tcld_pkg::is_sep(s1_byte_r);

  always_comb begin
    inside_upd = inside_r;
    rec_upd    = rec_r;
    count_upd  = count_r;
    if (s1_go) begin
      if (sep) begin
        inside_upd = 1'b0;
      end else if (!inside_r) begin
        inside_upd = 1'b1;
        if (count_r < CNT_W'(MAX_TOKENS)) begin
          count_upd = count_r + CNT_W'(1);
          rec_upd   = 1'b1;
        end else begin
          rec_upd = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (line_done) begin
      inside_nxt = 1'b0;
      rec_nxt    = 1'b0;
      count_nxt  = '0;
    end else begin
      inside_nxt = inside_upd;
      rec_nxt    = rec_upd;
      count_nxt  = count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      rec_r    <= 1'b0;
      count_r  <= '0;
    end else begin
      inside_r <= inside_nxt;
      rec_r    <= rec_nxt;
      count_r  <= count_nxt;
    end
  end

  // Upper-case the byte and route it to the slot of the current token; only the first KEPT tokens have a slot.
  assign store = s1_go && !sep && rec_upd;
  assign ch_up = ((s1_byte_r >= tcld_pkg::CH_LA) && (s1_byte_r <= tcld_pkg::CH_LZ)) ?
                 (s1_byte_r - tcld_pkg::CASE_GAP) : s1_byte_r;

  for (genvar i = 0; i < KEPT; i++) begin : g_slot
    assign slot_ctl[i].clear = line_done;
    assign slot_ctl[i].store = store && (count_upd == CNT_W'(i + 1));
    assign slot_ctl[i].ch    = ch_up;

    tcld_token_slot #(
      .TOKEN_SLOT_BYTES (TOKEN_SLOT_BYTES)
    ) u_slot (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (slot_ctl[i]),
      .hit     (hit[i]),
      .sig_app (sig_app[i])
    );
  end

  // The rate argument is the significant text of the second token.
  assign rate_ctl.clear = line_done;
  assign rate_ctl.store = sig_app[1];
  assign rate_ctl.ch    = ch_up;

  tcld_rate_acc u_rate (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rate_ctl),
    .ok    (rate_ok),
    .value (rate_val)
  );

  // Command decision on the state that includes the current byte.
  always_comb begin
    cmd  = tcld_pkg::CMD_UNKNOWN;
    rate = '0;
    if (count_upd == '0) begin
      cmd = tcld_pkg::CMD_NONE;
    end else if (hit[0][tcld_pkg::W_PING]) begin
      cmd = tcld_pkg::CMD_PING;
    end else if (count_upd < CNT_W'(2)) begin
      cmd = tcld_pkg::CMD_UNKNOWN;
    end else if (hit[0][tcld_pkg::W_STREAM]) begin
      if (hit[1][tcld_pkg::W_ON]) begin
        cmd = tcld_pkg::CMD_STREAM_ON;
      end else if (hit[1][tcld_pkg::W_OFF]) begin
        cmd = tcld_pkg::CMD_STREAM_OFF;
      end
    end else if (hit[0][tcld_pkg::W_RATE]) begin
      if (rate_ok) begin
        cmd  = tcld_pkg::CMD_RATE;
        rate = rate_val;
      end
    end else if (hit[0][tcld_pkg::W_OTOS]) begin
      if (hit[1][tcld_pkg::W_RESET]) begin
        cmd = tcld_pkg::CMD_OTOS_RESET;
      end
    end else if (hit[0][tcld_pkg::W_CAL]) begin
      if (hit[1][tcld_pkg::W_CARPET]) begin
        cmd = tcld_pkg::CMD_CAL_CARPET;
      end else if (hit[1][tcld_pkg::W_WHITE]) begin
        cmd = tcld_pkg::CMD_CAL_WHITE;
      end else if (hit[1][tcld_pkg::W_SAVE]) begin
        cmd = tcld_pkg::CMD_CAL_SAVE;
      end else if (hit[1][tcld_pkg::W_LOAD]) begin
        cmd = tcld_pkg::CMD_CAL_LOAD;
      end else if (hit[1][tcld_pkg::W_AUTO] && (count_upd >= CNT_W'(3))) begin
        if (hit[2][tcld_pkg::W_ON]) begin
          cmd = tcld_pkg::CMD_AUTO_ON;
        end else if (hit[2][tcld_pkg::W_OFF]) begin
          cmd = tcld_pkg::CMD_AUTO_OFF;
        end
      end
    end
  end

  // Result register: loaded at a line end, emptied by an output transfer.
  always_comb begin
    if (line_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (line_done) begin
      out_cmd_r  <= cmd;
      out_rate_r <= rate;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_rate_r, out_cmd_r};

  // A result only appears after a line end has been processed.
  `TCLD_ASSERT(a_result_after_line_end, clk, rst_n, $rose(out_valid_r) |-> $past(line_done))
  // A rate is only reported with the RATE command.
  `TCLD_ASSERT(a_rate_only_for_rate, clk, rst_n, out_valid_r |-> ((out_cmd_r == tcld_pkg::CMD_RATE) || (out_rate_r == '0)))
  // Token state is clear after every line end.
  `TCLD_ASSERT(a_clear_after_line, clk, rst_n, line_done |=> ((count_r == '0) && !inside_r && !rec_r))
  // The token count never passes its limit once reset has been applied.
  `TCLD_ASSERT_ALWAYS(a_count_bounded, clk, (!rst_n) || (count_r <= CNT_W'(MAX_TOKENS)))

endmodule
`default_nettype wire
